### hw/rtl/lsac_pkg.sv
// Package: shared constants and types for the cache tag store.
`default_nettype none
package lsac_pkg;
  localparam int LINE_COUNT   = 512;
  localparam int OFFSET_BITS  = 5;
  localparam int ADDRESS_BITS = 32;
  localparam int MAX_WAYS     = 16;
  localparam int LINE_LOG     = $clog2(LINE_COUNT);
  localparam int WAY_LOG      = $clog2(MAX_WAYS);
  localparam int SET_LOG      = LINE_LOG - 1;           // sets at 2 ways
  localparam int TAG_W        = ADDRESS_BITS - OFFSET_BITS - (LINE_LOG - WAY_LOG) + 1;
  localparam int RANK_W       = 4;
  localparam int CNT_W        = 32;

  localparam logic CFG_WAYS_LOG2   = 1'b0;
  localparam logic CFG_POLICY_MODE = 1'b1;

  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [SET_LOG-1:0] set_t;

  // One way of a set as held in the row memory.
  typedef struct packed {
    logic  valid;
    rank_t rank;
    tag_t  tag;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DRD, ST_DWB, ST_PRD, ST_PWB, ST_OUT
  } state_t;

  typedef struct packed {
    logic found;
    row_t row;
  } upd_t;
endpackage
`default_nettype wire

### hw/rtl/lsac_set_update.sv
// Set update: tag match, victim choice and LRU aging for one set row.
`default_nettype none
module lsac_set_update import lsac_pkg::*; (
  input  row_t             row_in,
  input  logic [2:0]       wl,
  input  tag_t             tag,
  input  logic             fill,
  output upd_t             upd
);
  logic [MAX_WAYS-1:0] act, match, empty;
  logic [WAY_LOG-1:0]  pick, epick, opick;
  logic                found, has_empty;
  rank_t               orank, limit;
  logic [RANK_W:0]     lim_ext;

  always_comb begin
    found = 1'b0; pick = '0; has_empty = 1'b0; epick = '0; opick = '0;
    orank = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      act[w]   = (w < (1 << wl));
      match[w] = act[w] && row_in[w].valid && (row_in[w].tag == tag);
      empty[w] = act[w] && !row_in[w].valid;
    end
    for (int w = MAX_WAYS-1; w >= 0; w--) begin
      if (match[w]) begin found = 1'b1; pick = WAY_LOG'(w); end
      if (empty[w]) begin has_empty = 1'b1; epick = WAY_LOG'(w); end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (act[w] && row_in[w].valid && (row_in[w].rank > orank || w == 0)) begin
        opick = WAY_LOG'(w); orank = row_in[w].rank;
      end
    end
    if (!found) pick = has_empty ? epick : opick;
    limit = row_in[pick].rank;
    lim_ext = found ? {1'b0, limit} : (5'd1 << wl);
    upd.found = found;
    upd.row = row_in;
    if (found || fill) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (act[w] && WAY_LOG'(w) != pick && row_in[w].valid &&
            {1'b0, row_in[w].rank} < lim_ext && row_in[w].rank != 4'hF)
          upd.row[w].rank = row_in[w].rank + 1'b1;
      end
      upd.row[pick].rank = '0;
      if (!found) begin
        upd.row[pick].valid = 1'b1;
        upd.row[pick].tag   = tag;
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/lru_set_assoc_cache_prefetch_core.sv
// Top level: LRU set-associative tag store with next-line prefetch.
//
// Input channel in_valid/in_ready carries in_cmd (0 load, 1 store) and
// in_address. Each item gives one result on out_valid/out_ready: out_hit
// and out_hit_total, the saturating count of demand hits including this one.
// The store lives in one row memory, one row per set slot (256 rows of
// 16 ways, a row holding 2^ways_log2 sets side by side is not used: each
// row is one set, only its first 2^ways_log2 ways active).
// Each item passes through demand read, demand write-back and, with
// prefetch, next-line read and next-line write-back, then the result
// state. The next item is accepted only back in the idle state, after
// the previous result has been taken. The result is held in the result
// state; a stalled receiver holds the block until the result is taken.
// Reset, and any configuration write, runs a clearing pass over all
// 256 rows of the memory; items are not accepted meanwhile, nor in the
// cycle of a configuration write or the one after it. Configuration writes
// (cfg_valid/cfg_ready, cfg_index, cfg_data) are accepted at any time
// and must only be issued while idle. Index 0 is ways_log2, 1 policy_mode.
// The hit counter is cleared by reset only.
`default_nettype none
module lru_set_assoc_cache_prefetch_core import lsac_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [31:0]      out_hit_total,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [2:0]  cfg_data
);
  localparam int ROWS = 1 << SET_LOG;

  state_t      state_r, state_nxt;
  logic [2:0]  wl_r;
  logic [1:0]  mode_r;
  logic        cmd_r, hit_r, clr_req_r;
  set_t        set_r, nset_r, clr_r;
  tag_t        tag_r, ntag_r;
  logic [CNT_W-1:0] cnt_r;
  row_t        mem [ROWS];
  row_t        rd_r;
  logic        we;
  set_t        waddr, raddr;
  row_t        wdata;
  logic [2:0]  wl;
  upd_t        upd;
  tag_t        utag;
  logic        ufill;
  logic [ADDRESS_BITS-OFFSET_BITS-1:0] line;
  set_t        smask, iset;
  tag_t        itag;

  assign cfg_ready = 1'b1;
  assign wl = (wl_r < 3'd1) ? 3'd1 : (wl_r > 3'(WAY_LOG)) ? 3'(WAY_LOG) : wl_r;
  assign line  = in_address[ADDRESS_BITS-1:OFFSET_BITS];
  assign smask = set_t'((1 << (LINE_LOG - wl)) - 1);
  assign iset  = line[SET_LOG-1:0] & smask;
  assign itag  = tag_t'({1'b0, line} >> (LINE_LOG - wl));

  assign utag  = (state_r == ST_DWB) ? tag_r : ntag_r;
  assign ufill = (state_r == ST_DWB) ? !(mode_r == 2'd1 && cmd_r) : 1'b1;

  lsac_set_update u_upd (.row_in(rd_r), .wl(wl), .tag(utag), .fill(ufill), .upd(upd));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    in_ready = 1'b0;
    out_valid = 1'b0;
    we = 1'b0; waddr = set_r; wdata = upd.row; raddr = set_r;
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_r; wdata = '0;
        if (clr_r == set_t'(ROWS-1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        // hold off while a configuration write is starting a clear
        in_ready = !clr_req_r && !cfg_valid;
        raddr = iset;
        if (in_valid && in_ready) state_nxt = ST_DRD;
      end
      ST_DRD: state_nxt = ST_DWB;
      ST_DWB: begin
        we = 1'b1;
        raddr = nset_r;
        if (mode_r == 2'd2 || (mode_r == 2'd3 && !upd.found)) state_nxt = ST_PRD;
        else state_nxt = ST_OUT;
      end
      ST_PRD: begin raddr = nset_r; state_nxt = ST_PWB; end
      ST_PWB: begin we = 1'b1; waddr = nset_r; state_nxt = ST_OUT; end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
    if (clr_req_r && state_r != ST_CLEAR) state_nxt = ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; clr_r <= '0; wl_r <= 3'd1; mode_r <= 2'd0;
      cnt_r <= '0; clr_req_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_req_r <= 1'b0;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      else clr_r <= '0;
      if (cfg_valid) begin
        if (cfg_index == CFG_WAYS_LOG2) wl_r <= cfg_data;
        else mode_r <= cfg_data[1:0];
        clr_req_r <= 1'b1;
        if (state_r == ST_CLEAR) clr_r <= '0;
      end
      if (state_r == ST_DWB && upd.found && cnt_r != '1) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd; set_r <= iset; tag_r <= itag;
      if (iset == smask) begin nset_r <= '0; ntag_r <= itag + 1'b1; end
      else begin nset_r <= iset + 1'b1; ntag_r <= itag; end
    end
    if (state_r == ST_DWB) hit_r <= upd.found;
  end

  assign out_hit = hit_r;
  assign out_hit_total = cnt_r;

`ifndef SYNTHESIS
  a_no_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");
  a_wb_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRD |=> state_r == ST_DWB || state_r == ST_CLEAR)
    else $error("demand write-back skipped");
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r >= $past(cnt_r)) else $error("hit count fell");
`endif
endmodule
`default_nettype wire
